>>> design/dq_pkg.sv
package dq_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;
   localparam logic [OP_W-1:0] OP_SWAP       = 3'd5;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_FEW   = 2'd3;

   localparam logic signed [DATA_W-1:0] POP_EMPTY = -32'sd1;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped;
      logic [ST_W-1:0]          status;
      logic [CNT_W-1:0]         count;
   } rsp_type;

endpackage

>>> design/dq_mem.sv
module dq_mem #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               we,
   input  logic [$clog2(DEPTH)-1:0]           waddr,
   input  logic signed [dq_pkg::DATA_W-1:0]   wdata,
   input  logic [$clog2(DEPTH)-1:0]           raddr0,
   input  logic [$clog2(DEPTH)-1:0]           raddr1,
   output logic signed [dq_pkg::DATA_W-1:0]   rdata0,
   output logic signed [dq_pkg::DATA_W-1:0]   rdata1
);
   import dq_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd0_ff;
   logic signed [DATA_W-1:0] rd1_ff;
   logic signed [DATA_W-1:0] wd_ff;
   logic                     fwd0_ff;
   logic                     fwd0_in;
   logic                     fwd1_ff;
   logic                     fwd1_in;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd0_ff <= mem[raddr0];
      rd1_ff <= mem[raddr1];
      wd_ff  <= wdata;
   end

   // write-through bypass for a read of the slot written in the same cycle
   assign fwd0_in = we && (waddr == raddr0);
   assign fwd1_in = we && (waddr == raddr1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd0_ff <= 1'b0;
         fwd1_ff <= 1'b0;
      end else begin
         fwd0_ff <= fwd0_in;
         fwd1_ff <= fwd1_in;
      end
   end

   assign rdata0 = fwd0_ff ? wd_ff : rd0_ff;
   assign rdata1 = fwd1_ff ? wd_ff : rd1_ff;

   a_bypass0: assert property (@(posedge clock) disable iff (reset)
      (we && (waddr == raddr0)) |=> (rdata0 == $past(wdata)))
      else $error("front read misses same-cycle write");

   a_bypass1: assert property (@(posedge clock) disable iff (reset)
      (we && (waddr == raddr1)) |=> (rdata1 == $past(wdata)))
      else $error("back read misses same-cycle write");

endmodule

>>> design/dq_ctrl.sv
module dq_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               acc,
   input  logic [dq_pkg::OP_W-1:0]            op,
   input  logic signed [dq_pkg::DATA_W-1:0]   val,
   input  logic signed [dq_pkg::DATA_W-1:0]   fv,
   input  logic signed [dq_pkg::DATA_W-1:0]   bv,
   output logic                               we,
   output logic [$clog2(DEPTH)-1:0]           waddr,
   output logic signed [dq_pkg::DATA_W-1:0]   wdata,
   output logic [$clog2(DEPTH)-1:0]           raddr0,
   output logic [$clog2(DEPTH)-1:0]           raddr1,
   output logic                               busy,
   output dq_pkg::rsp_type                    rsp
);
   import dq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] inc(input logic [AW-1:0] x);
      return (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
   endfunction

   function automatic logic [AW-1:0] dec(input logic [AW-1:0] x);
      return (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
   endfunction

   logic [AW-1:0]            front_ff, front_in;
   logic [AW-1:0]            back_ff, back_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     rev_ff, rev_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pwaddr_ff, pwaddr_in;
   logic signed [DATA_W-1:0] pwdata_ff, pwdata_in;

   logic [AW-1:0] front_out;
   logic [AW-1:0] front_step;
   logic [AW-1:0] back_out;
   logic [AW-1:0] back_step;
   logic          empty;
   logic          full;
   logic          few;

   always_comb begin
      front_out  = rev_ff ? inc(front_ff) : dec(front_ff);
      front_step = rev_ff ? dec(front_ff) : inc(front_ff);
      back_out   = rev_ff ? dec(back_ff) : inc(back_ff);
      back_step  = rev_ff ? inc(back_ff) : dec(back_ff);
      empty      = (count_ff == '0);
      full       = (count_ff >= CW'(DEPTH));
      few        = (count_ff < CW'(2));

      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      rev_in     = rev_ff;
      pend_in    = 1'b0;
      pwaddr_in  = pwaddr_ff;
      pwdata_in  = pwdata_ff;
      // second write of a swap
      we         = pend_ff;
      waddr      = pwaddr_ff;
      wdata      = pwdata_ff;
      rsp.popped = '0;
      rsp.status = ST_OK;

      if (acc) begin
         unique case (op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp.status = ST_FULL;
               end else begin
                  we       = 1'b1;
                  waddr    = front_out;
                  wdata    = val;
                  front_in = front_out;
                  if (empty) begin
                     back_in = front_out;
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  rsp.status = ST_FULL;
               end else begin
                  we       = 1'b1;
                  waddr    = empty ? front_ff : back_out;
                  wdata    = val;
                  back_in  = empty ? front_ff : back_out;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rsp.popped = POP_EMPTY;
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.popped = fv;
                  front_in   = front_step;
                  count_in   = count_ff - CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  rsp.popped = POP_EMPTY;
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.popped = bv;
                  back_in    = back_step;
                  count_in   = count_ff - CW'(1);
               end
            end
            OP_REVERSE: begin
               rev_in = !rev_ff;
               if (!empty) begin
                  front_in = back_ff;
                  back_in  = front_ff;
               end
            end
            OP_SWAP: begin
               if (few) begin
                  rsp.status = ST_FEW;
               end else begin
                  we        = 1'b1;
                  waddr     = front_ff;
                  wdata     = bv;
                  pend_in   = 1'b1;
                  pwaddr_in = back_ff;
                  pwdata_in = fv;
               end
            end
            default: begin
            end
         endcase
      end

      rsp.count = CNT_W'(count_in);
   end

   assign raddr0 = front_in;
   assign raddr1 = back_in;
   assign busy   = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pwaddr_ff <= pwaddr_in;
      pwdata_ff <= pwdata_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_pend_once: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("swap write pending for two cycles");

   a_pend_no_transfer: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !acc)
      else $error("transfer taken during swap write");

endmodule

>>> design/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values, DEPTH entries deep. Every request
// transfer gives exactly one response transfer, registered in the next cycle. Push, pop
// and reverse accept one request per cycle while no response is held under rsp_stall;
// a swap of the end entries that succeeds stalls the next request, because the second
// slot write goes through the single memory write port in the following cycle, during
// which req_stall is high. The front and back values are prefetched from the slot
// memory every cycle with write bypass, so pops read no memory on the request path.
// req_stall is also high while a response waits in the output register under rsp_stall.
// rsp_count is the held entry count modulo 32.
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dq_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [dq_pkg::DATA_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [dq_pkg::DATA_W-1:0]   rsp_popped,
   output logic [dq_pkg::ST_W-1:0]            rsp_status,
   output logic [dq_pkg::CNT_W-1:0]           rsp_count
);
   import dq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                     acc;
   logic                     busy;
   logic                     we;
   logic [AW-1:0]            waddr;
   logic signed [DATA_W-1:0] wdata;
   logic [AW-1:0]            raddr0;
   logic [AW-1:0]            raddr1;
   logic signed [DATA_W-1:0] fv;
   logic signed [DATA_W-1:0] bv;
   rsp_type                  rsp;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   assign req_stall    = busy || (rsp_valid_ff && rsp_stall);
   assign acc          = req_valid && !req_stall;
   assign rsp_valid_in = acc || (rsp_valid_ff && rsp_stall);

   dq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .op    (req_opcode),
      .val   (req_value),
      .fv    (fv),
      .bv    (bv),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr0(raddr0),
      .raddr1(raddr1),
      .busy  (busy),
      .rsp   (rsp)
   );

   dq_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr0(raddr0),
      .raddr1(raddr1),
      .rdata0(fv),
      .rdata1(bv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_popped = rsp_ff.popped;
   assign rsp_status = rsp_ff.status;
   assign rsp_count  = rsp_ff.count;

endmodule
